FILE: sv/srd_pkg.sv
// Shared types and constants for the signed restoring divider.
// Holds the data width, the per-stage record and the special operand values.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package srd_pkg;

    // Operand and quotient width
    localparam int DATA_WIDTH = 32;

    // Register stages: one operand stage, one per quotient bit, one output stage
    localparam int NUM_STAGES = DATA_WIDTH + 2;

    typedef logic [DATA_WIDTH-1:0] data_t;

    // Special two's complement values
    localparam data_t INT_MIN   = {1'b1, {(DATA_WIDTH-1){1'b0}}};
    localparam data_t INT_MAX   = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam data_t MINUS_ONE = {DATA_WIDTH{1'b1}};

    // Payload carried through the quotient-bit stages
    typedef struct packed {
        data_t rem;   // partial remainder, always below den when den is nonzero
        data_t nq;    // unused dividend bits on top, quotient bits shifted in below
        data_t den;   // divisor magnitude
        logic  neg;   // result sign
        logic  dz;    // zero divisor
        logic  ovf;   // most negative divided by minus one
    } stage_t;

endpackage : srd_pkg

`default_nettype wire

FILE: sv/signed_restoring_divider.sv
// Signed restoring divider: pipelined, one quotient bit per stage; depends on srd_pkg.
// A beat passes through one operand stage, 32 subtract stages and one output stage,
// in that order, before it shows on the result side.
// Throughput: one beat per cycle; the whole pipe advances whenever the output
// stage is empty or its beat is taken, and holds as a unit otherwise.
// Reset clears all stage valid bits; payload registers are not reset.
`timescale 1ns / 1ps
`default_nettype none

module signed_restoring_divider
    import srd_pkg::*;
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    // request channel
    input  wire logic                         req_valid,
    output logic                              req_ready,
    input  wire logic signed [DATA_WIDTH-1:0] dividend,
    input  wire logic signed [DATA_WIDTH-1:0] divisor,
    // result channel
    output logic                              rsp_valid,
    input  wire logic                         rsp_ready,
    output logic signed [DATA_WIDTH-1:0]      quotient,
    output logic                              overflow,
    output logic                              divide_by_zero
);

    // One restoring step: shift in the next dividend bit, trial subtract
    function automatic stage_t div_step(stage_t s);
        logic [DATA_WIDTH:0] shifted;
        logic [DATA_WIDTH:0] diff;
        stage_t              r;
        shifted = {s.rem, s.nq[DATA_WIDTH-1]};
        diff    = shifted - {1'b0, s.den};
        r       = s;
        if (!diff[DATA_WIDTH])
        begin
            r.rem = diff[DATA_WIDTH-1:0];
            r.nq  = {s.nq[DATA_WIDTH-2:0], 1'b1};
        end
        else
        begin
            r.rem = shifted[DATA_WIDTH-1:0];
            r.nq  = {s.nq[DATA_WIDTH-2:0], 1'b0};
        end
        return r;
    endfunction

    // Stage 0 holds the operand magnitudes, stages 1..DATA_WIDTH the steps
    stage_t                st_reg  [0:DATA_WIDTH];
    stage_t                st_next [0:DATA_WIDTH];
    logic [NUM_STAGES-1:0] vld_reg;
    logic [NUM_STAGES-1:0] vld_next;

    data_t                 quot_reg;
    data_t                 quot_next;
    logic                  ovf_reg;
    logic                  ovf_next;
    logic                  dz_reg;
    logic                  dz_next;

    data_t                 a_u;
    data_t                 b_u;
    data_t                 q_mag;
    logic                  advance;

    // Whole pipe moves when the output stage is free or being drained
    assign advance   = !vld_reg[NUM_STAGES-1] || rsp_ready;
    assign req_ready = advance;
    assign vld_next  = {vld_reg[NUM_STAGES-2:0], req_valid};

    assign a_u = data_t'(dividend);
    assign b_u = data_t'(divisor);

    // Operand stage and bit stage next values
    always_comb
    begin
        st_next[0].rem = '0;
        st_next[0].nq  = a_u[DATA_WIDTH-1] ? (~a_u + data_t'(1)) : a_u;
        st_next[0].den = b_u[DATA_WIDTH-1] ? (~b_u + data_t'(1)) : b_u;
        st_next[0].neg = a_u[DATA_WIDTH-1] ^ b_u[DATA_WIDTH-1];
        st_next[0].dz  = (b_u == '0);
        st_next[0].ovf = (a_u == INT_MIN) && (b_u == MINUS_ONE);
        for (int k = 1; k <= DATA_WIDTH; k++)
        begin
            st_next[k] = div_step(st_reg[k-1]);
        end
    end

    // Sign fix-up and special cases
    assign q_mag = st_reg[DATA_WIDTH].nq;

    always_comb
    begin
        dz_next  = st_reg[DATA_WIDTH].dz;
        ovf_next = st_reg[DATA_WIDTH].ovf && !st_reg[DATA_WIDTH].dz;
        if (st_reg[DATA_WIDTH].dz)
            quot_next = '0;
        else if (st_reg[DATA_WIDTH].ovf)
            quot_next = INT_MAX;
        else if (st_reg[DATA_WIDTH].neg)
            quot_next = ~q_mag + data_t'(1);
        else
            quot_next = q_mag;
    end

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (advance)
            vld_reg <= vld_next;
    end

    // Payload, no reset
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            for (int k = 0; k <= DATA_WIDTH; k++)
            begin
                st_reg[k] <= st_next[k];
            end
            quot_reg <= quot_next;
            ovf_reg  <= ovf_next;
            dz_reg   <= dz_next;
        end
    end

    assign rsp_valid      = vld_reg[NUM_STAGES-1];
    assign quotient       = $signed(quot_reg);
    assign overflow       = ovf_reg;
    assign divide_by_zero = dz_reg;

    // Checks
    a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> !(overflow && divide_by_zero))
        else $error("overflow and divide_by_zero both set");

    a_dz_zero_quot: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && divide_by_zero) |-> (quot_reg == '0))
        else $error("nonzero quotient on zero divisor");

    a_ovf_saturates: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && overflow) |-> (quot_reg == INT_MAX))
        else $error("overflow without saturated quotient");

    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (vld_reg[DATA_WIDTH] && !st_reg[DATA_WIDTH].dz)
            |-> (st_reg[DATA_WIDTH].rem < st_reg[DATA_WIDTH].den))
        else $error("final remainder not below divisor");

    a_dz_captured: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready && (divisor == '0)) |=> (vld_reg[0] && st_reg[0].dz))
        else $error("zero divisor not flagged in operand stage");

endmodule : signed_restoring_divider

`default_nettype wire
